// ----- src/sbot_pkg.sv -----
// ---------------------------------------------------------------------------
// sbot_pkg: shared types and constants for the segment/box occlusion test
// Coordinate, slab-fraction and product widths; register indexes.
// ---------------------------------------------------------------------------
package sbot_pkg;

   localparam int COORD_W = 24;
   localparam int EXT_W   = 23;
   localparam int IDX_W   = 3;
   localparam int NAXES   = 3;
   localparam int EYE_OFFSET = 5120;

   // doubled coordinates and bounds
   localparam int O_W   = COORD_W + 2;
   localparam int B_W   = COORD_W + 3;
   localparam int N_W   = COORD_W + 4;
   localparam int DEN_W = COORD_W + 1;
   localparam int PROD_W = N_W + DEN_W + 1;

   localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_START_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_END_X   = 3'd3;
   localparam logic [IDX_W-1:0] REG_END_Y   = 3'd4;
   localparam logic [IDX_W-1:0] REG_END_Z   = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [EXT_W-1:0]          ext_type;
   typedef logic signed [N_W-1:0]     num_type;
   typedef logic [DEN_W-1:0]          den_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      num_type n1;
      num_type n2;
      den_type den;
      logic    par;
   } axis_type;

   typedef struct packed {
      axis_type [NAXES-1:0] ax;
      logic                 pass;
      logic                 zero;
      logic                 fin;
   } item_type;

   typedef struct packed {
      num_type lo_n;
      den_type lo_d;
      num_type hi_n;
      den_type hi_d;
   } track_type;

   typedef struct packed {
      item_type  item;
      track_type trk;
   } stage_type;

   function automatic prod_type mul(num_type a, den_type b);
      prod_type ae;
      prod_type be;
      ae = prod_type'(a);
      be = prod_type'($signed({1'b0, b}));
      return ae * be;
   endfunction

endpackage

// ----- src/sbot_if.sv -----
// ---------------------------------------------------------------------------
// sbot_req_if / sbot_rsp_if: box and result channels
// Valid/ready channels carrying one box and one occlusion result per beat.
// ---------------------------------------------------------------------------
interface sbot_req_if;
   logic                  valid;
   logic                  ready;
   logic signed [23:0]    center_x;
   logic signed [23:0]    center_y;
   logic signed [23:0]    center_z;
   logic [22:0]           extent_x;
   logic [22:0]           extent_y;
   logic [22:0]           extent_z;
   logic                  final_box;
   modport source (output valid, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, final_box, input ready);
   modport sink   (input valid, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, final_box, output ready);
endinterface

interface sbot_rsp_if;
   logic valid;
   logic ready;
   logic blocked;
   logic zero_length;
   logic final_result;
   modport source (output valid, blocked, zero_length, final_result, input ready);
   modport sink   (input valid, blocked, zero_length, final_result, output ready);
endinterface

// ----- src/sbot_prep.sv -----
// ---------------------------------------------------------------------------
// sbot_prep: slab setup stage
// Turns one box into doubled slab bounds, entry/exit numerators and
// denominators per axis, and resolves axes parallel to the segment.
// ---------------------------------------------------------------------------
module sbot_prep (
   input  logic                      clock,
   input  logic                      reset,
   sbot_req_if.sink                  req,
   input  sbot_pkg::coord_type [2:0] sp,
   input  sbot_pkg::coord_type [2:0] ep,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sbot_pkg::stage_type       out_data
);
   import sbot_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   coord_type [2:0] cen;
   ext_type   [2:0] ext;

   assign cen = {req.center_z, req.center_y, req.center_x};
   assign ext = {req.extent_z, req.extent_y, req.extent_x};
   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      logic signed [COORD_W:0] sum;
      logic signed [COORD_W:0] dif;
      logic signed [O_W-1:0]   o;
      logic signed [O_W-1:0]   d;
      logic signed [O_W-1:0]   dneg;
      logic signed [B_W-1:0]   bmin;
      logic signed [B_W-1:0]   bmax;
      logic signed [B_W-1:0]   ee;
      logic signed [COORD_W:0] c2;
      num_type                 a;
      num_type                 b;
      data_in = '0;
      data_in.item.pass = 1'b1;
      data_in.item.zero = 1'b1;
      for (int k = 0; k < NAXES; k++) begin
         sum  = (COORD_W+1)'(sp[k]) + ((k == 1) ? (COORD_W+1)'(EYE_OFFSET) : '0);
         dif  = (COORD_W+1)'(ep[k]) - (COORD_W+1)'(sp[k]);
         o    = {sum, 1'b0};
         d    = {dif, 1'b0};
         dneg = -d;
         c2   = {cen[k], 1'b0};
         ee   = B_W'($signed({1'b0, ext[k]}));
         bmin = B_W'(c2) - ee;
         bmax = B_W'(c2) + ee;
         a    = N_W'(bmin) - N_W'(o);
         b    = N_W'(bmax) - N_W'(o);
         if (d < 0) begin
            data_in.item.ax[k].n1  = -b;
            data_in.item.ax[k].n2  = -a;
            data_in.item.ax[k].den = dneg[DEN_W-1:0];
         end else begin
            data_in.item.ax[k].n1  = a;
            data_in.item.ax[k].n2  = b;
            data_in.item.ax[k].den = d[DEN_W-1:0];
         end
         data_in.item.ax[k].par = (d == '0);
         if (d != '0) data_in.item.zero = 1'b0;
         if (d == '0 && (a > 0 || b < 0)) data_in.item.pass = 1'b0;
      end
      data_in.item.fin = req.final_box;
      data_in.trk.lo_n = '0;
      data_in.trk.lo_d = den_type'(1);
      data_in.trk.hi_n = num_type'(1);
      data_in.trk.hi_d = den_type'(1);
   end

   assign valid_in = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (req.ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ----- src/sbot_slab.sv -----
// ---------------------------------------------------------------------------
// sbot_slab: one axis of the slab test
// Cross-multiplies the axis entry/exit fractions against the running
// interval, then narrows the interval; two register stages.
// ---------------------------------------------------------------------------
module sbot_slab #(
   parameter int AXIS = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sbot_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sbot_pkg::stage_type out_data
);
   import sbot_pkg::*;

   logic      va_ff, va_in, vb_ff, vb_in;
   logic      ra, rb;
   stage_type da_ff, db_ff, db_in;
   prod_type  plo_ff, qlo_ff, phi_ff, qhi_ff;
   axis_type  axa, axb;

   assign rb = !vb_ff || out_ready;
   assign ra = !va_ff || rb;
   assign in_ready = ra;
   assign axa = in_data.item.ax[AXIS];
   assign axb = da_ff.item.ax[AXIS];

   assign va_in = ra ? in_valid : va_ff;
   assign vb_in = rb ? va_ff : vb_ff;

   always_comb begin
      db_in = da_ff;
      if (!axb.par) begin
         if (plo_ff > qlo_ff) begin
            db_in.trk.lo_n = axb.n1;
            db_in.trk.lo_d = axb.den;
         end
         if (phi_ff > qhi_ff) begin
            db_in.trk.hi_n = axb.n2;
            db_in.trk.hi_d = axb.den;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
      if (ra) begin
         da_ff  <= in_data;
         plo_ff <= mul(axa.n1, in_data.trk.lo_d);
         qlo_ff <= mul(in_data.trk.lo_n, axa.den);
         phi_ff <= mul(in_data.trk.hi_n, axa.den);
         qhi_ff <= mul(axa.n2, in_data.trk.hi_d);
      end
      if (rb) db_ff <= db_in;
   end

   assign out_valid = vb_ff;
   assign out_data  = db_ff;
endmodule

// ----- src/sbot_final.sv -----
// ---------------------------------------------------------------------------
// sbot_final: interval check and result register
// Compares entry against exit by cross multiplication and forms the
// result beat.
// ---------------------------------------------------------------------------
module sbot_final (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sbot_pkg::stage_type in_data,
   sbot_rsp_if.source          rsp
);
   import sbot_pkg::*;

   logic     va_ff, va_in, vb_ff, vb_in;
   logic     ra, rb;
   item_type ia_ff;
   prod_type l_ff, h_ff;
   logic     blk_ff, zero_ff, fin_ff;

   assign rb = !vb_ff || rsp.ready;
   assign ra = !va_ff || rb;
   assign in_ready = ra;
   assign va_in = ra ? in_valid : va_ff;
   assign vb_in = rb ? va_ff : vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
      if (ra) begin
         ia_ff <= in_data.item;
         l_ff  <= mul(in_data.trk.lo_n, in_data.trk.hi_d);
         h_ff  <= mul(in_data.trk.hi_n, in_data.trk.lo_d);
      end
      if (rb) begin
         blk_ff  <= !ia_ff.zero && ia_ff.pass && !(l_ff > h_ff);
         zero_ff <= ia_ff.zero;
         fin_ff  <= ia_ff.fin;
      end
   end

   assign rsp.valid        = vb_ff;
   assign rsp.blocked      = blk_ff;
   assign rsp.zero_length  = zero_ff;
   assign rsp.final_result = fin_ff;
endmodule

// ----- src/segment_box_occlusion_test_core.sv -----
// ---------------------------------------------------------------------------
// segment_box_occlusion_test_core: line-of-sight test against boxes
// Slab-method segment versus axis-aligned box test, exact in fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Write the segment start and end points (Q16.8, y before eye offset)
//   through csr_we/csr_index/csr_wdata while no box is in flight.
//   Each req beat carries one box as center and full size; each rsp beat
//   returns blocked, zero_length and a copy of final_box, in order, one
//   response for every box.
//   Pipeline: nine register stages (setup stage, two stages per axis for the
//   multiply and interval update, two for the final entry/exit compare).
//   Throughput: one box per cycle while rsp is not stalled; the four
//   28x26 multipliers per axis stage set the stage depth.
//   Reset clears all pipeline valids and the segment registers to zero.
//   When rsp is stalled, each stage holds until the one after it frees up,
//   so bubbles are squeezed out and req.ready drops only when every stage
//   is full.
// ---------------------------------------------------------------------------
module segment_box_occlusion_test_core (
   input  logic                       clock,
   input  logic                       reset,
   sbot_req_if.sink                   req,
   sbot_rsp_if.source                 rsp,
   input  logic                       csr_we,
   input  logic [sbot_pkg::IDX_W-1:0] csr_index,
   input  logic [sbot_pkg::COORD_W-1:0] csr_wdata
);
   import sbot_pkg::*;

   coord_type [2:0] sp_ff;
   coord_type [2:0] ep_ff;
   logic      [3:0] v;
   logic      [3:0] r;
   stage_type [3:0] d;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         ep_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_X: sp_ff[0] <= csr_wdata;
            REG_START_Y: sp_ff[1] <= csr_wdata;
            REG_START_Z: sp_ff[2] <= csr_wdata;
            REG_END_X:   ep_ff[0] <= csr_wdata;
            REG_END_Y:   ep_ff[1] <= csr_wdata;
            REG_END_Z:   ep_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   sbot_prep u_prep (
      .clock, .reset, .req, .sp(sp_ff), .ep(ep_ff),
      .out_valid(v[0]), .out_ready(r[0]), .out_data(d[0])
   );

   for (genvar k = 0; k < NAXES; k++) begin : g_axis
      sbot_slab #(.AXIS(k)) u_slab (
         .clock, .reset,
         .in_valid(v[k]), .in_ready(r[k]), .in_data(d[k]),
         .out_valid(v[k+1]), .out_ready(r[k+1]), .out_data(d[k+1])
      );
   end

   sbot_final u_final (
      .clock, .reset,
      .in_valid(v[3]), .in_ready(r[3]), .in_data(d[3]), .rsp
   );

   a_zero_not_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_length |-> !rsp.blocked)
      else $error("zero-length segment reported as blocked");

   a_zero_matches_cfg: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.zero_length == (sp_ff == ep_ff))
      else $error("zero_length disagrees with segment registers");

endmodule
